>>> hdl/shell_sort_engine_top_defines.svh
// Assertion macros shared by the shell sort engine checker.
// No dependencies; included by the checker file only.
`ifndef SHELL_SORT_ENGINE_TOP_DEFINES_SVH
`define SHELL_SORT_ENGINE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sse_pkg.sv
// Package for the shell sort engine: defaults, microcode word layout and the program ROM.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package sse_pkg;

  localparam int unsigned MAX_ITEMS_DEF  = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned STEP_W         = 4;

  // Program steps; the step counter holds one of these.
  typedef enum logic [STEP_W-1:0] {
    ST_LOAD,
    ST_GAP_INIT,
    ST_GAP_TEST,
    ST_I_TEST,
    ST_HELD,
    ST_J_CMP,
    ST_J_READ,
    ST_PLACE,
    ST_HALVE,
    ST_OUT_RD,
    ST_OUT_WR,
    ST_OUT_CHK,
    ST_CLEAR
  } step_e;

  typedef enum logic [1:0] {RD_I, RD_J, RD_K} rd_sel_e;
  typedef enum logic [1:0] {WR_NONE, WR_LOAD, WR_MOVE, WR_HELD} wr_sel_e;
  typedef enum logic [1:0] {GAP_KEEP, GAP_INIT, GAP_HALVE} gap_op_e;
  typedef enum logic [1:0] {I_KEEP, I_FROM_GAP, I_INC} i_op_e;
  typedef enum logic [1:0] {J_KEEP, J_START, J_STEP} j_op_e;

  // Jump conditions: when true the counter loads the target, else it steps on.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_END,
    C_GAP_ZERO,
    C_I_GE_N,
    C_NO_MOVE,
    C_NOT_SENT,
    C_K_LT_N
  } cond_e;

  typedef struct packed {
    logic    in_rdy;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    gap_op_e gap_op;
    i_op_e   i_op;
    j_op_e   j_op;
    logic    held_ld;
    logic    out_send;
    logic    clear;
    cond_e   cond;
    step_e   target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_e step);
    ucode_t w;
    w = '0;
    case (step)
      ST_LOAD: begin
        w.in_rdy = 1'b1;
        w.wr_sel = WR_LOAD;
        w.cond   = C_NOT_END;
        w.target = ST_LOAD;
      end
      ST_GAP_INIT: begin
        w.gap_op = GAP_INIT;
      end
      ST_GAP_TEST: begin
        w.i_op   = I_FROM_GAP;
        w.cond   = C_GAP_ZERO;
        w.target = ST_OUT_RD;
      end
      ST_I_TEST: begin
        w.rd_sel = RD_I;
        w.j_op   = J_START;
        w.cond   = C_I_GE_N;
        w.target = ST_HALVE;
      end
      ST_HELD: begin
        w.held_ld = 1'b1;
        w.rd_sel  = RD_J;
      end
      ST_J_CMP: begin
        w.rd_sel = RD_J;
        w.wr_sel = WR_MOVE;
        w.j_op   = J_STEP;
        w.cond   = C_NO_MOVE;
        w.target = ST_PLACE;
      end
      ST_J_READ: begin
        w.rd_sel = RD_J;
        w.cond   = C_ALWAYS;
        w.target = ST_J_CMP;
      end
      ST_PLACE: begin
        w.wr_sel = WR_HELD;
        w.i_op   = I_INC;
        w.cond   = C_ALWAYS;
        w.target = ST_I_TEST;
      end
      ST_HALVE: begin
        w.gap_op = GAP_HALVE;
        w.cond   = C_ALWAYS;
        w.target = ST_GAP_TEST;
      end
      ST_OUT_RD: begin
        w.rd_sel = RD_K;
      end
      ST_OUT_WR: begin
        w.rd_sel   = RD_K;
        w.out_send = 1'b1;
        w.cond     = C_NOT_SENT;
        w.target   = ST_OUT_WR;
      end
      ST_OUT_CHK: begin
        w.rd_sel = RD_K;
        w.cond   = C_K_LT_N;
        w.target = ST_OUT_WR;
      end
      ST_CLEAR: begin
        w.clear  = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = ST_LOAD;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sse_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module sse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/shell_sort_engine_top.sv
// Shell sort engine: loads a set one beat per cycle, sorts it in place, streams it out.
// Sorting runs insertion passes over halving gaps; as the store has a single read port, a
// shift is followed by a fresh read before the further compare. Each result is read from
// the store, then waits for room in the output register; the next set may start loading
// while the final result still waits. Reset is asynchronous, active low, and clears the
// step counter, counters, fill count and output valid but not the store.
`default_nettype none

module shell_sort_engine_top #(
  parameter int unsigned MAX_ITEMS  = sse_pkg::MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = sse_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream. tdata: value, then zero padding to whole bytes.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  // Output stream. tdata: sorted_value, then zero padding to whole bytes.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [((VALUE_BITS + 7) / 8) * 8-1:0]      m_axis_tdata,
  output logic                                     m_axis_tlast,
  // tuser: overflow (elements of this set were dropped).
  output logic                                     m_axis_tuser
);

  import sse_pkg::*;

  localparam int unsigned DATA_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_ITEMS);

  // Sequencer state and the control word of the current step.
  step_e  upc_q, upc_d;
  ucode_t uc;

  // Counters and indices. All are CNT_W wide; the store is addressed by part-select.
  logic [CNT_W-1:0] n_q, n_d;       // fill count of the current set
  logic [CNT_W-1:0] gap_q, gap_d;
  logic [CNT_W-1:0] i_q, i_d;       // element being inserted
  logic [CNT_W-1:0] j_q, j_d;       // element being compared against
  logic [CNT_W-1:0] pos_q, pos_d;   // hole where the held element will land
  logic [CNT_W-1:0] k_q, k_d;       // output index
  logic             ovf_q, ovf_d;

  logic signed [VALUE_BITS-1:0] held_q, held_d;
  logic signed [VALUE_BITS-1:0] rdata;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;
  logic                  out_ovf_q, out_ovf_d;

  // Store port signals.
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic in_beat;
  logic full;
  logic less;
  logic j_ge_gap;
  logic slot_free;
  logic send;
  logic jump;

  sse_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The control word comes straight from the program ROM.
  always_comb begin
    uc = ucode_rom(upc_q);
  end

  assign rdata     = $signed(ram_rdata);
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign full      = (n_q == CNT_W'(MAX_ITEMS));
  // Strict compare: an element moves only past values that are greater than it.
  assign less      = (held_q < rdata);
  assign j_ge_gap  = (j_q >= gap_q);
  // The output register can take a result when it is empty or being emptied now.
  assign slot_free = !out_valid_q || m_axis_tready;
  assign send      = uc.out_send && slot_free;

  // Jump condition of the current step.
  always_comb begin
    case (uc.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NOT_END:  jump = !(in_beat && s_axis_tlast);
      C_GAP_ZERO: jump = (gap_q == '0);
      C_I_GE_N:   jump = (i_q >= n_q);
      C_NO_MOVE:  jump = !(less && j_ge_gap);
      C_NOT_SENT: jump = !slot_free;
      C_K_LT_N:   jump = (k_q < n_q);
      default:    jump = 1'b1;
    endcase
  end

  // Next step.
  always_comb begin
    if (jump) begin
      upc_d = uc.target;
    end else begin
      upc_d = step_e'(upc_q + STEP_W'(1));
    end
  end

  // Read address: the store always reads, and the data shows up in the next cycle.
  always_comb begin
    case (uc.rd_sel)
      RD_I:    ram_raddr = i_q[IDX_W-1:0];
      RD_J:    ram_raddr = j_q[IDX_W-1:0];
      RD_K:    ram_raddr = k_q[IDX_W-1:0];
      default: ram_raddr = k_q[IDX_W-1:0];
    endcase
  end

  // Write port: loading a beat, shifting a larger element up, or dropping the held one in.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q[IDX_W-1:0];
    ram_wdata = held_q;
    case (uc.wr_sel)
      WR_NONE: begin
        ram_we = 1'b0;
      end
      WR_LOAD: begin
        ram_we    = in_beat && !full;
        ram_waddr = n_q[IDX_W-1:0];
        ram_wdata = s_axis_tdata[VALUE_BITS-1:0];
      end
      WR_MOVE: begin
        ram_we    = less;
        ram_wdata = ram_rdata;
      end
      WR_HELD: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Datapath register updates under control of the current word.
  always_comb begin
    n_d    = n_q;
    ovf_d  = ovf_q;
    gap_d  = gap_q;
    i_d    = i_q;
    j_d    = j_q;
    pos_d  = pos_q;
    k_d    = k_q;
    held_d = held_q;

    if (uc.wr_sel == WR_LOAD && in_beat) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        n_d = n_q + CNT_W'(1);
      end
    end

    case (uc.gap_op)
      GAP_KEEP:  gap_d = gap_q;
      GAP_INIT:  gap_d = n_q >> 1;
      GAP_HALVE: gap_d = gap_q >> 1;
      default:   gap_d = gap_q;
    endcase

    case (uc.i_op)
      I_KEEP:     i_d = i_q;
      I_FROM_GAP: i_d = gap_q;
      I_INC:      i_d = i_q + CNT_W'(1);
      default:    i_d = i_q;
    endcase

    case (uc.j_op)
      J_KEEP: begin
        j_d = j_q;
      end
      J_START: begin
        j_d   = i_q - gap_q;
        pos_d = i_q;
      end
      J_STEP: begin
        if (less) begin
          pos_d = j_q;
          if (j_ge_gap) begin
            j_d = j_q - gap_q;
          end
        end
      end
      default: begin
        j_d = j_q;
      end
    endcase

    if (uc.held_ld) begin
      held_d = rdata;
    end

    if (send) begin
      k_d = k_q + CNT_W'(1);
    end

    // End of the set: empty the block for the next one.
    if (uc.clear) begin
      n_d   = '0;
      ovf_d = 1'b0;
      k_d   = '0;
    end
  end

  // Output register: loaded from the store's read data, emptied by the downstream beat.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    if (send) begin
      out_valid_d = 1'b1;
      out_data_d  = ram_rdata;
      out_last_d  = (k_q == n_q - CNT_W'(1));
      out_ovf_d   = ovf_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ST_LOAD;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      gap_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      n_q         <= n_d;
      ovf_q       <= ovf_d;
      gap_q       <= gap_d;
      i_q         <= i_d;
      j_q         <= j_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign s_axis_tready = uc.in_rdy;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'(out_data_q);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

`default_nettype wire

>>> hdl/sse_checker.sv
// Port-level checker for the shell sort engine, bound to the top level.
// Depends on shell_sort_engine_top_defines.svh for the assertion macros.
`default_nettype none
`include "shell_sort_engine_top_defines.svh"

module sse_checker #(
  parameter int unsigned DATA_W = 32
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              s_axis_tlast,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [DATA_W-1:0] m_axis_tdata,
  input wire logic              m_axis_tlast,
  input wire logic              m_axis_tuser
);

  // A stalled result beat stays offered.
  `SSE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat withdrawn while stalled")

  // A stalled result beat keeps its payload.
  `SSE_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result payload changed while stalled")

  // The closing input beat starts the sort, so input is refused in the next cycle.
  `SSE_ASSERT_NEXT(a_sort_after_last, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken straight after the closing beat")

  // While results of a set are still to come, no new set is being loaded.
  `SSE_ASSERT_SAME(a_no_load_mid_output, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input accepted while a set is still being emitted")

endmodule

bind shell_sort_engine_top sse_checker #(
  .DATA_W (((VALUE_BITS + 7) / 8) * 8)
) u_sse_checker (.*);

`default_nettype wire

>>> dv/tb_shell_sort_engine_top.sv
// Self-checking testbench for shell_sort_engine_top: streams sets of signed values in and
// checks every sorted beat against an in-bench Shell sort predictor. Depends on sse_pkg.
module tb_shell_sort_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = sse_pkg::MAX_ITEMS_DEF;
  localparam int unsigned VB  = sse_pkg::VALUE_BITS_DEF;
  localparam int unsigned DW  = ((VB + 7) / 8) * 8;

  localparam logic [VB-1:0] V_MIN = {1'b1, {(VB - 1){1'b0}}};
  localparam logic [VB-1:0] V_MAX = {1'b0, {(VB - 1){1'b1}}};

  // One beat offered to the engine: the value and whether it closes the set.
  typedef struct packed {
    logic [VB-1:0] value;
    logic          last;
  } elem_beat_t;

  // One sorted beat we expect to see leave the engine.
  typedef struct packed {
    logic [VB-1:0] value;
    logic          last;
    logic          ovf;
  } sorted_beat_t;

  // Directed sets, written as {last, value}: single minimum, single maximum, a reversed
  // pair, a run of equal values, a mixed set spanning both signs with alternating bit
  // patterns, and a strictly descending set.
  localparam int unsigned N_DIRECTED = 21;
  localparam logic [VB:0] DIRECTED_SETS [0:N_DIRECTED-1] = '{
    {1'b1, V_MIN},
    {1'b1, V_MAX},
    {1'b0, 32'sd5},         {1'b1, -32'sd3},
    {1'b0, 32'sd7},         {1'b0, 32'sd7},        {1'b1, 32'sd7},
    {1'b0, V_MAX},          {1'b0, 32'sd0},        {1'b0, -32'sd1},     {1'b0, V_MIN},
    {1'b0, 32'sd1},         {1'b0, 32'hAAAA_AAAA}, {1'b0, 32'h5555_5555}, {1'b1, -32'sd1},
    {1'b0, 32'sd30},        {1'b0, 32'sd20},       {1'b0, 32'sd10},
    {1'b0, -32'sd10},       {1'b0, -32'sd20},      {1'b1, -32'sd30}
  };

  logic          clk_i         = 1'b1;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata  = '0;
  logic          s_axis_tlast  = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic          m_axis_tlast;
  logic          m_axis_tuser;

  shell_sort_engine_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 8 ns clock, high then low.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Beats waiting to be offered, the beat currently on the bus, and the sorted beats that
  // the predictor has promised but the engine has not yet delivered.
  elem_beat_t           pending_beats [$];
  elem_beat_t           on_bus;
  sorted_beat_t         sorted_expect [$];

  // Predictor state: the elements of the set being loaded and whether any were dropped.
  logic signed [VB-1:0] set_elems [$];
  logic                 set_dropped = 1'b0;

  int                   send_idle     = 0;
  int                   recv_idle     = 0;
  int                   beats_taken   = 0;
  int                   mismatches    = 0;
  logic                 hold_long     = 1'b0;

  // Gap lengths: mostly none, often short, now and then a long pause.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // Values: full-range random for bit coverage, a narrow band so that duplicates are
  // common, and the signed extremes around zero.
  function automatic logic [VB-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return $urandom;
    end else if (r < 75) begin
      return VB'($signed($urandom_range(0, 16)) - 8);
    end else begin
      case ($urandom_range(0, 3))
        0:       return V_MIN;
        1:       return V_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
  endfunction

  function automatic void queue_beat(input logic [VB-1:0] value, input logic last);
    elem_beat_t b;
    b.value = value;
    b.last  = last;
    pending_beats.push_back(b);
  endfunction

  function automatic void queue_random_set(input int n);
    for (int k = 0; k < n; k++)
      queue_beat(pick_value(), k == n - 1);
  endfunction

  // Predictor, run on every accepted input beat. Elements beyond capacity are dropped and
  // mark the set. A beat with last closes the set: the stored elements are put in order by
  // Shell sort with halving gaps (an element only moves past strictly greater ones) and
  // every one becomes an expected sorted beat.
  function automatic void take_element(input elem_beat_t b);
    logic signed [VB-1:0] arr [$];
    logic signed [VB-1:0] held;
    sorted_beat_t         e;
    int                   n;
    int                   gap;
    int                   j;
    if (set_elems.size() < CAP)
      set_elems.push_back(b.value);
    else
      set_dropped = 1'b1;
    if (b.last) begin
      arr = set_elems;
      n   = arr.size();
      for (gap = n / 2; gap > 0; gap = gap / 2) begin
        for (int i = gap; i < n; i++) begin
          held = arr[i];
          j    = i - gap;
          while (j >= 0) begin
            if (!(held < arr[j]))
              break;
            arr[j + gap] = arr[j];
            j = j - gap;
          end
          arr[j + gap] = held;
        end
      end
      for (int k = 0; k < n; k++) begin
        e.value = arr[k];
        e.last  = (k == n - 1);
        e.ovf   = set_dropped;
        sorted_expect.push_back(e);
      end
      set_elems.delete();
      set_dropped = 1'b0;
    end
  endfunction

  // Compare one delivered beat with the oldest expectation, field by field.
  function automatic void check_sorted_beat();
    sorted_beat_t e;
    if (sorted_expect.size() == 0) begin
      $display("%0t: unexpected beat, value %0d last %0b overflow %0b", $time,
               $signed(m_axis_tdata[VB-1:0]), m_axis_tlast, m_axis_tuser);
      mismatches++;
    end else begin
      e = sorted_expect.pop_front();
      if (m_axis_tdata[VB-1:0] !== e.value) begin
        $display("%0t: value expected %0d actual %0d", $time, $signed(e.value),
                 $signed(m_axis_tdata[VB-1:0]));
        mismatches++;
      end
      if (m_axis_tlast !== e.last) begin
        $display("%0t: tlast expected %0b actual %0b", $time, e.last, m_axis_tlast);
        mismatches++;
      end
      if (m_axis_tuser !== e.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, m_axis_tuser);
        mismatches++;
      end
    end
  endfunction

  // Sender. A beat stays on the bus until the engine takes it; only then is the predictor
  // told about it and the next beat, or an idle gap, chosen. Each signal is assigned once
  // per edge, so a back-to-back beat keeps tvalid high without a glitch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      send_idle     <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        take_element(on_bus);
        beats_taken <= beats_taken + 1;
      end
      if (send_idle != 0) begin
        s_axis_tvalid <= 1'b0;
        send_idle     <= send_idle - 1;
      end else if (pending_beats.size() != 0) begin
        on_bus         = pending_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'(on_bus.value);
        s_axis_tlast  <= on_bus.last;
        send_idle     <= pick_idle();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. Checks each accepted beat, then decides tready for the next edge: held low
  // throughout the long hold-off, otherwise low for random stretches now and again.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_idle     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_sorted_beat();
      if (hold_long) begin
        m_axis_tready <= 1'b0;
      end else if (recv_idle != 0) begin
        m_axis_tready <= 1'b0;
        recv_idle     <= recv_idle - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          recv_idle <= pick_idle();
      end
    end
  end

  // Long hold-off. Once the run is well under way the receiver stops taking beats for a
  // good while; the sender keeps offering, so the engine finishes its sort, parks on the
  // first result, may load the next set and then has to refuse further input.
  initial begin
    while (beats_taken < 150)
      @(posedge clk_i);
    hold_long <= 1'b1;
    repeat (600) @(posedge clk_i);
    hold_long <= 1'b0;
  end

  // Stimulus and the end of the run.
  initial begin
    int queued;
    for (int k = 0; k < N_DIRECTED; k++)
      queue_beat(DIRECTED_SETS[k][VB-1:0], DIRECTED_SETS[k][VB]);

    // Random part. A full set and an overflowing one are always present; the rest are
    // mostly small sets, some medium ones and the odd set near or past capacity; in a set
    // past capacity the closing element itself is then dropped.
    queued = 0;
    queue_random_set(CAP);
    queued += CAP;
    while (queued < 400) begin
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 78)
        n = $urandom_range(1, 12);
      else if (r < 92)
        n = $urandom_range(13, 40);
      else
        n = $urandom_range(CAP - 1, CAP + 6);
      if (queued < 200 && queued + n >= 200) begin
        queue_random_set(CAP + 3);
        queued += CAP + 3;
      end
      queue_random_set(n);
      queued += n;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to be taken and every sorted beat to arrive, then give the
    // engine time to show any stray output.
    while (pending_beats.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    while (sorted_expect.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run including the long hold-off.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sse_pkg.sv
hdl/sse_ram.sv
hdl/shell_sort_engine_top.sv
hdl/sse_checker.sv
dv/tb_shell_sort_engine_top.sv
